// File: hdl/threshold_pattern_zoom_3x_unit_defines.svh
// Assertion macros for the checker file of the zoom unit.
// No dependencies; expects clk and rst in the scope of use.
`ifndef THRESHOLD_PATTERN_ZOOM_3X_UNIT_DEFINES_SVH
`define THRESHOLD_PATTERN_ZOOM_3X_UNIT_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define TZM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tzm check failed");

// Consequent must hold in the cycle after any reset cycle.
`define TZM_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("tzm reset check failed");

`endif

// File: hdl/tzm_pkg.sv
// Shared types and constants of the 3x threshold-pattern zoom unit.
// No dependencies.
package tzm_pkg;

  localparam int CHAN_W  = 8;
  localparam int DIM_W   = 11;
  localparam int THR_W   = 9;
  localparam int COORD_W = 12;
  localparam int ADDR_W  = 24;

  localparam int DEFAULT_MAX_DIM = 1024;
  localparam int ZOOM            = 3;
  localparam int SUB_W           = 2;   // holds an offset 0..ZOOM-1 inside a block
  localparam int JOB_QUEUE_DEPTH = 2;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DARK_THRESHOLD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MID_THRESHOLD   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_THRESHOLD = 3'd4;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH     = 11'd1024;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT    = 11'd1024;
  localparam logic [THR_W-1:0] RST_DARK_THRESHOLD  = 9'd75;
  localparam logic [THR_W-1:0] RST_MID_THRESHOLD   = 9'd135;
  localparam logic [THR_W-1:0] RST_LIGHT_THRESHOLD = 9'd180;

  typedef enum logic [1:0] {
    TIER_BLACK,
    TIER_CENTER,
    TIER_RING,
    TIER_FULL
  } tier_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  blue_out;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [ADDR_W-1:0]  out_address;
    logic               block_last;
  } sub_pixel_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [THR_W-1:0] dark_threshold;
    logic [THR_W-1:0] mid_threshold;
    logic [THR_W-1:0] light_threshold;
  } cfg_t;

  // One classified pixel, ready for expansion into its block.
  typedef struct packed {
    pixel_in_t          color;
    tier_t              tier;
    logic [COORD_W-1:0] col3;      // 3 * column, low bits
    logic [COORD_W-1:0] row3;      // 3 * row, low bits
    logic [ADDR_W-1:0]  col_base;  // 3 * column for the address
    logic [ADDR_W-1:0]  row_base;  // 3 * row * 3 * width
    logic [ADDR_W-1:0]  stride;    // 3 * width
  } job_t;

endpackage

// File: hdl/tzm_queue.sv
// Short job queue between the classifying front and the expanding back.
// Depends on tzm_pkg.
module tzm_queue import tzm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

  job_t             entries [JOB_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_W'(JOB_QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

// File: hdl/tzm_front.sv
// Front of the zoom unit: takes pixels, sorts them into tiers, tracks the
// raster position and forms the block base address. Depends on tzm_pkg.
module tzm_front import tzm_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      push,
  output logic      full,
  input  pixel_in_t pixel,
  output logic      q_push,
  output job_t      q_job,
  input  logic      q_full
);

  localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LIM_W = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
  localparam int PRD_W = CNT_W + LIM_W + 4;

  logic [CNT_W-1:0]   column_count;
  logic [CNT_W-1:0]   row_count;
  logic [LIM_W-1:0]   width_lim;
  logic [LIM_W-1:0]   height_lim;
  logic [CNT_W+1:0]   col_x3;
  logic [CNT_W+1:0]   row_x3;
  logic [LIM_W+1:0]   width_x3;
  logic [PRD_W-1:0]   row_product;
  logic               col_wrap;
  logic               row_wrap;
  tier_t              tier;

  function automatic logic [LIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [LIM_W-1:0] ve;
    ve = LIM_W'(v);
    if (v == '0) begin
      return LIM_W'(1);
    end else if (ve > LIM_W'(MAX_DIM)) begin
      return LIM_W'(MAX_DIM);
    end
    return ve;
  endfunction

  function automatic logic all_below(input pixel_in_t p, input logic [THR_W-1:0] t);
    return (THR_W'(p.red_in) < t) && (THR_W'(p.green_in) < t) && (THR_W'(p.blue_in) < t);
  endfunction

  assign full   = q_full;
  assign q_push = push && !q_full;

  assign width_lim  = clamp_dim(cfg.image_width);
  assign height_lim = clamp_dim(cfg.image_height);

  assign col_x3   = (CNT_W+2)'(column_count) + {1'b0, column_count, 1'b0};
  assign row_x3   = (CNT_W+2)'(row_count) + {1'b0, row_count, 1'b0};
  assign width_x3 = (LIM_W+2)'(width_lim) + {1'b0, width_lim, 1'b0};
  assign row_product = PRD_W'(row_x3) * PRD_W'(width_x3);

  // First threshold that every channel stays under picks the pattern.
  always_comb begin
    priority if (all_below(pixel, cfg.dark_threshold)) begin
      tier = TIER_BLACK;
    end else if (all_below(pixel, cfg.mid_threshold)) begin
      tier = TIER_CENTER;
    end else if (all_below(pixel, cfg.light_threshold)) begin
      tier = TIER_RING;
    end else begin
      tier = TIER_FULL;
    end
  end

  always_comb begin
    q_job.color    = pixel;
    q_job.tier     = tier;
    q_job.col3     = COORD_W'(col_x3);
    q_job.row3     = COORD_W'(row_x3);
    q_job.col_base = ADDR_W'(col_x3);
    q_job.row_base = ADDR_W'(row_product);
    q_job.stride   = ADDR_W'(width_x3);
  end

  // A counter at or past a smaller new size also wraps here.
  assign col_wrap = (LIM_W'(column_count) + LIM_W'(1)) >= width_lim;
  assign row_wrap = (LIM_W'(row_count) + LIM_W'(1)) >= height_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (q_push) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/tzm_back.sv
// Back of the zoom unit: expands a job into nine sub-pixels, one per cycle
// while pops keep up, into an output register. Depends on tzm_pkg.
module tzm_back import tzm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  job_t       q_head,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output sub_pixel_t sub_pixel
);

  logic              active;
  job_t              job;
  logic [SUB_W-1:0]  dx;
  logic [SUB_W-1:0]  dy;
  logic [ADDR_W-1:0] line_addr;
  logic              out_valid;
  sub_pixel_t        out_reg;
  sub_pixel_t        sub_next;

  logic last_sub;
  logic row_end;
  logic advance;
  logic load;
  logic center;
  logic lit;

  assign row_end  = (dx == SUB_W'(ZOOM - 1));
  assign last_sub = row_end && (dy == SUB_W'(ZOOM - 1));
  assign advance  = active && (!out_valid || pop);
  // Pick up the next job on the cycle the last sub-pixel goes out.
  assign load     = !q_empty && (!active || (advance && last_sub));
  assign q_pop    = load;

  assign center = (dx == SUB_W'(1)) && (dy == SUB_W'(1));

  always_comb begin
    unique case (job.tier)
      TIER_BLACK:  lit = 1'b0;
      TIER_CENTER: lit = center;
      TIER_RING:   lit = !center;
      TIER_FULL:   lit = 1'b1;
      default:     lit = 1'b1;
    endcase
  end

  always_comb begin
    sub_next.red_out     = lit ? job.color.red_in   : '0;
    sub_next.green_out   = lit ? job.color.green_in : '0;
    sub_next.blue_out    = lit ? job.color.blue_in  : '0;
    sub_next.out_col     = job.col3 + COORD_W'(dx);
    sub_next.out_row     = job.row3 + COORD_W'(dy);
    sub_next.out_address = line_addr + ADDR_W'(dx);
    sub_next.block_last  = last_sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
      end else if (advance && last_sub) begin
        active <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job       <= q_head;
      dx        <= '0;
      dy        <= '0;
      line_addr <= q_head.row_base + q_head.col_base;
    end else if (advance) begin
      if (row_end) begin
        dx        <= '0;
        dy        <= dy + SUB_W'(1);
        line_addr <= line_addr + job.stride;
      end else begin
        dx <= dx + SUB_W'(1);
      end
    end
    if (advance) begin
      out_reg <= sub_next;
    end
  end

  assign empty     = !out_valid;
  assign sub_pixel = out_reg;

endmodule

// File: hdl/threshold_pattern_zoom_3x_unit.sv
// Pixels go in on a queue-style port (push/full): one 8-bit RGB pixel per
// transaction, in raster order. Each pixel is sorted by the dark, mid and
// light thresholds into one of four patterns and comes out as nine
// sub-pixels of a 3x3 block on the result port (empty/pop), row by row,
// with output column, row and linear address; the ninth carries block_last.
// The first sub-pixel of a pixel passes the job queue, the back end's job
// register and the output register. Throughput: one sub-pixel per cycle
// while the receiver pops, set by the nine sub-pixels of each pixel sharing
// the one result port; a two-entry job queue lets the front take pixels
// while the back end works.
// A stalled receiver holds the current sub-pixel on the ports; the back end
// stops, the queue fills and full rises.
// Reset clears the raster counters, the queue and the output valid flag and
// loads the default size 1024x1024 and thresholds 75, 135 and 180. The APB
// port (pready always high) writes and reads the five registers at byte
// addresses 0, 4, 8, 12 and 16; write them only while the block is idle.
module threshold_pattern_zoom_3x_unit import tzm_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  pixel_in_t             pixel,
  input  logic                  pop,
  output logic                  empty,
  output sub_pixel_t            sub_pixel
);

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t q_wr_job;
  job_t q_head;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width     <= RST_IMAGE_WIDTH;
      cfg.image_height    <= RST_IMAGE_HEIGHT;
      cfg.dark_threshold  <= RST_DARK_THRESHOLD;
      cfg.mid_threshold   <= RST_MID_THRESHOLD;
      cfg.light_threshold <= RST_LIGHT_THRESHOLD;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:     cfg.image_width     <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= pwdata[DIM_W-1:0];
        REG_DARK_THRESHOLD:  cfg.dark_threshold  <= pwdata[THR_W-1:0];
        REG_MID_THRESHOLD:   cfg.mid_threshold   <= pwdata[THR_W-1:0];
        REG_LIGHT_THRESHOLD: cfg.light_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:     prdata = APB_DATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT:    prdata = APB_DATA_W'(cfg.image_height);
      REG_DARK_THRESHOLD:  prdata = APB_DATA_W'(cfg.dark_threshold);
      REG_MID_THRESHOLD:   prdata = APB_DATA_W'(cfg.mid_threshold);
      REG_LIGHT_THRESHOLD: prdata = APB_DATA_W'(cfg.light_threshold);
      default:             prdata = '0;
    endcase
  end

  tzm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .pixel  (pixel),
    .q_push (q_push),
    .q_job  (q_wr_job),
    .q_full (q_full)
  );

  tzm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (q_wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty)
  );

  tzm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .sub_pixel (sub_pixel)
  );

endmodule

// File: hdl/tzm_checker.sv
// Port-level checks of the zoom unit, bound to the top level.
// Depends on tzm_pkg and threshold_pattern_zoom_3x_unit_defines.svh.
`include "threshold_pattern_zoom_3x_unit_defines.svh"

module tzm_checker import tzm_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input sub_pixel_t sub_pixel
);

  // A waiting sub-pixel holds until taken.
  `TZM_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(sub_pixel))

  // Inside a block the next sub-pixel follows right after each transaction.
  `TZM_ASSERT_NEXT(a_block_dense, pop && !empty && !sub_pixel.block_last, !empty)

  // Nothing is offered right after reset.
  `TZM_ASSERT_AFTER_RESET(a_reset_empty, empty)

  // The input side is open right after reset.
  `TZM_ASSERT_AFTER_RESET(a_reset_not_full, !full)

endmodule

bind threshold_pattern_zoom_3x_unit tzm_checker u_tzm_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .pop       (pop),
  .empty     (empty),
  .sub_pixel (sub_pixel)
);
